// File: rtl/hrd_pkg.sv
package hrd_pkg;

	localparam int LENGTH_BITS     = 32;
	localparam int SIZE_LINE_LIMIT = 31;
	localparam int MIN_STATUS_LINE = 12;

	typedef logic [LENGTH_BITS-1:0] len_t;

	localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_STATUS  = 3'd0,
		PH_HEADERS = 3'd1,
		PH_CONTENT = 3'd2,
		PH_SIZE    = 3'd3,
		PH_DATA    = 3'd4,
		PH_TRAILER = 3'd5,
		PH_DONE    = 3'd6,
		PH_ERROR   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_STATUS  = 2'd1,
		ERR_EOS     = 2'd2,
		ERR_TRAILER = 2'd3
	} err_t;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_EOS  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       body_valid;
		logic [7:0] body_byte;
		logic [9:0] resp_status;
		logic       response_done;
		logic [1:0] error_kind;
	} out_item_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] lit_proto(input logic [2:0] i);
		case (i)
			3'd0: return 8'h48;
			3'd1: return 8'h54;
			3'd2: return 8'h54;
			3'd3: return 8'h50;
			3'd4: return 8'h2F;
			3'd5: return 8'h31;
			3'd6: return 8'h2E;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] lit_cl(input logic [3:0] i);
		case (i)
			4'd0: return "c";  4'd1: return "o";  4'd2: return "n";  4'd3: return "t";
			4'd4: return "e";  4'd5: return "n";  4'd6: return "t";  4'd7: return "-";
			4'd8: return "l";  4'd9: return "e";  4'd10: return "n"; 4'd11: return "g";
			4'd12: return "t"; 4'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] lit_te(input logic [4:0] i);
		case (i)
			5'd0: return "t";  5'd1: return "r";  5'd2: return "a";  5'd3: return "n";
			5'd4: return "s";  5'd5: return "f";  5'd6: return "e";  5'd7: return "r";
			5'd8: return "-";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "c";
			5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
			5'd16: return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] lit_chunked(input logic [2:0] i);
		case (i)
			3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
			3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
			default: return 8'h00;
		endcase
	endfunction

endpackage

// File: rtl/hrd_stream_if.sv
interface hrd_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/hrd_core.sv
// Next-state and result logic for one transaction; purely combinational.
module hrd_core
	import hrd_pkg::*;
(
	input  phase_t     phase,
	input  logic [7:0] line_pos,
	input  logic       prev_cr,
	input  logic [9:0] status_acc,
	input  logic [3:0] sl_flags,
	input  logic [3:0] hm_flags,
	input  len_t       value_acc,
	input  logic       len_known,
	input  len_t       decl_len,
	input  logic       chunked,
	input  len_t       body_cnt,
	input  len_t       chunk_left,
	input  logic       trl_step,
	input  in_item_t   item,
	output phase_t     phase_n,
	output logic [7:0] line_pos_n,
	output logic       prev_cr_n,
	output logic [9:0] status_acc_n,
	output logic [3:0] sl_flags_n,
	output logic [3:0] hm_flags_n,
	output len_t       value_acc_n,
	output logic       len_known_n,
	output len_t       decl_len_n,
	output logic       chunked_n,
	output len_t       body_cnt_n,
	output len_t       chunk_left_n,
	output logic       trl_step_n,
	output out_item_t  result
);

	// Saturating decimal accumulate: acc*10+d, clamp at max
	function automatic len_t sat_dec(input len_t acc, input logic [3:0] d, input len_t mx);
		logic [LENGTH_BITS+4:0] w;
		w = {5'd0, acc} * (LENGTH_BITS+5)'(10) + (LENGTH_BITS+5)'(d);
		return (w > {5'd0, mx}) ? mx : w[LENGTH_BITS-1:0];
	endfunction

	function automatic len_t sat_hex(input len_t acc, input logic [3:0] d);
		logic [LENGTH_BITS+3:0] w;
		w = {acc, 4'd0} | (LENGTH_BITS+4)'(d);
		return (w[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX : w[LENGTH_BITS-1:0];
	endfunction

	function automatic logic [7:0] inc_pos(input logic [7:0] p);
		return (p != 8'hFF) ? p + 8'd1 : p;
	endfunction

	logic [7:0] c;
	logic       dig;
	logic [3:0] dval;
	logic       hexd;
	logic [3:0] hval;
	logic [7:0] lc;

	always_comb begin
		c    = item.data_byte;
		lc   = to_lower(c);
		dig  = c >= "0" && c <= "9";
		dval = c[3:0];
		hexd = dig || (lc >= "a" && lc <= "f");
		hval = dig ? c[3:0] : lc[3:0] + 4'd9;
	end

	// line character handling
	phase_t     lp_n;
	logic [7:0] lpos_n;
	logic [9:0] lsa_n;
	logic [3:0] lsl_n;
	logic [3:0] lhm_n;
	len_t       lva_n;
	logic       llk_n;
	len_t       ldl_n;
	logic       lch_n;
	len_t       lcl_n;
	logic       lpc_n;
	logic       l_done;
	logic       l_err;
	logic       is_end;
	logic [1:0] st;
	len_t       acc;
	logic       ok;

	always_comb begin
		lp_n   = phase;
		lpos_n = line_pos;
		lsa_n  = status_acc;
		lsl_n  = sl_flags;
		lhm_n  = hm_flags;
		lva_n  = value_acc;
		llk_n  = len_known;
		ldl_n  = decl_len;
		lch_n  = chunked;
		lcl_n  = chunk_left;
		lpc_n  = 1'b0;
		l_done = 1'b0;
		l_err  = 1'b0;
		st     = 2'd0;
		acc    = '0;
		ok     = 1'b0;
		is_end = prev_cr && c == 8'h0A;
		if (is_end) begin
			case (phase)
				PH_STATUS: begin
					ok = line_pos >= 8'(MIN_STATUS_LINE) && !sl_flags[0] && sl_flags[1]
						&& status_acc >= 10'd100 && status_acc <= 10'd599;
					if (ok) begin
						lp_n  = PH_HEADERS;
						llk_n = 1'b0;
						lch_n = 1'b0;
					end else begin
						lp_n  = PH_ERROR;
						lsa_n = '0;
						l_err = 1'b1;
					end
				end
				PH_HEADERS: begin
					if (!hm_flags[2]) begin
						if (line_pos == 8'd0) begin
							if (chunked) lp_n = PH_SIZE;
							else if (len_known && decl_len != '0) lp_n = PH_CONTENT;
							else if (len_known || status_acc == 10'd204 || status_acc == 10'd304) begin
								lp_n   = PH_DONE;
								l_done = 1'b1;
							end else lp_n = PH_CONTENT;
						end
					end else if (hm_flags[0]) begin
						if (hm_flags[3] && value_acc != '0) llk_n = 1'b0;
						else begin
							llk_n = 1'b1;
							ldl_n = value_acc;
						end
					end else if (hm_flags[1]) begin
						if (line_pos == 8'd7) lch_n = 1'b1;
					end
				end
				default: begin
					if (value_acc == '0) begin
						lp_n   = PH_DONE;
						l_done = 1'b1;
					end else begin
						lcl_n = value_acc;
						lp_n  = PH_DATA;
					end
				end
			endcase
			lpos_n = '0;
			lhm_n  = '0;
			lva_n  = '0;
		end else begin
			// Two characters may be consumed: a stray CR, then c. The stray CR is never a
			// digit, colon or space, so it only affects flags and position; handle it first.
			if (prev_cr) begin
				case (phase)
					PH_STATUS: begin
						if (line_pos < 8'd7) lsl_n[0] = 1'b1;
						if (lsl_n[1]) begin
							// CR is whitespace: only keeps state 0
							if (lsl_n[3:2] != 2'd0) lsl_n[3:2] = 2'd3;
						end
						lpos_n = inc_pos(line_pos);
					end
					PH_HEADERS: begin
						if (!lhm_n[2]) begin
							lhm_n[1:0] = 2'b11;
							lpos_n = inc_pos(line_pos);
						end else if (lhm_n[0]) begin
							if (line_pos[1:0] != 2'd0) lpos_n = 8'd3;
						end else if (lhm_n[1]) begin
							lhm_n[3] = 1'b1;
							if (line_pos < 8'd7) lpos_n = 8'd8;
						end
					end
					default: begin
						lpos_n = inc_pos(line_pos);
						if (line_pos < 8'(SIZE_LINE_LIMIT) && lhm_n != 4'd0) lhm_n = 4'd2;
					end
				endcase
			end
			if (c == 8'h0D) lpc_n = 1'b1;
			else begin
				case (phase)
					PH_STATUS: begin
						if (lpos_n < 8'd7 && c != lit_proto(lpos_n[2:0])) lsl_n[0] = 1'b1;
						if (!lsl_n[1]) begin
							if (c == " ") lsl_n[1] = 1'b1;
						end else begin
							st = lsl_n[3:2];
							if (st == 2'd0 && is_ws(c)) st = 2'd0;
							else if (st == 2'd0 && c == "+") st = 2'd1;
							else if (st == 2'd0 && c == "-") begin
								st    = 2'd3;
								lsa_n = '0;
							end else if (st != 2'd3 && dig) begin
								acc   = sat_dec(len_t'(status_acc), dval, len_t'(1000));
								lsa_n = acc[9:0];
								st    = 2'd2;
							end else st = 2'd3;
							lsl_n[3:2] = st;
						end
						lpos_n = inc_pos(lpos_n);
					end
					PH_HEADERS: begin
						if (!lhm_n[2]) begin
							if (c == ":") begin
								// a stray CR earlier on the line already broke both names
								lhm_n[0]   = !lhm_n[0] && lpos_n == 8'd14;
								lhm_n[1]   = !lhm_n[1] && lpos_n == 8'd17;
								lhm_n[3:2] = 2'b01;
								lpos_n = '0;
								lva_n  = '0;
							end else begin
								if (lpos_n >= 8'd14 || lc != lit_cl(lpos_n[3:0])) lhm_n[0] = 1'b1;
								if (lpos_n >= 8'd17 || lc != lit_te(lpos_n[4:0])) lhm_n[1] = 1'b1;
								lpos_n = inc_pos(lpos_n);
							end
						end else if (lhm_n[0]) begin
							st = lpos_n[1:0];
							if (st == 2'd0 && is_ws(c)) st = 2'd0;
							else if (st == 2'd0 && c == "+") st = 2'd1;
							else if (st == 2'd0 && c == "-") begin
								st = 2'd1;
								lhm_n[3] = 1'b1;
							end else if (st != 2'd3 && dig) begin
								lva_n = sat_dec(value_acc, dval, LEN_MAX);
								st    = 2'd2;
							end else st = 2'd3;
							lpos_n = {6'd0, st};
						end else if (lhm_n[1]) begin
							if (!(!lhm_n[3] && c == " ")) begin
								lhm_n[3] = 1'b1;
								if (lpos_n < 8'd7) begin
									if (lc == lit_chunked(lpos_n[2:0])) lpos_n = lpos_n + 8'd1;
									else lpos_n = 8'd8;
								end
							end
						end
					end
					default: begin
						if (lpos_n < 8'(SIZE_LINE_LIMIT)) begin
							if (lhm_n == 4'd0 && is_ws(c)) lhm_n = 4'd0;
							else if (lhm_n <= 4'd1 && hexd) begin
								lva_n = sat_hex(value_acc, hval);
								lhm_n = 4'd1;
							end else lhm_n = 4'd2;
						end
						lpos_n = inc_pos(lpos_n);
					end
				endcase
			end
		end
	end

	logic [1:0] err;
	logic       done;
	logic       bv;
	len_t       cl_dec;

	always_comb begin
		phase_n      = phase;
		line_pos_n   = line_pos;
		prev_cr_n    = prev_cr;
		status_acc_n = status_acc;
		sl_flags_n   = sl_flags;
		hm_flags_n   = hm_flags;
		value_acc_n  = value_acc;
		len_known_n  = len_known;
		decl_len_n   = decl_len;
		chunked_n    = chunked;
		body_cnt_n   = body_cnt;
		chunk_left_n = chunk_left;
		trl_step_n   = trl_step;
		err          = ERR_NONE;
		done         = 1'b0;
		bv           = 1'b0;
		cl_dec       = '0;
		if (phase == PH_DONE || phase == PH_ERROR) begin
		end else if (item.req_type == REQ_EOS) begin
			if (phase == PH_CONTENT && !len_known) begin
				phase_n = PH_DONE;
				done    = 1'b1;
			end else begin
				phase_n = PH_ERROR;
				err     = ERR_EOS;
			end
		end else begin
			case (phase)
				PH_STATUS, PH_HEADERS, PH_SIZE: begin
					phase_n      = lp_n;
					line_pos_n   = lpos_n;
					prev_cr_n    = lpc_n;
					status_acc_n = lsa_n;
					sl_flags_n   = lsl_n;
					hm_flags_n   = lhm_n;
					value_acc_n  = lva_n;
					len_known_n  = llk_n;
					decl_len_n   = ldl_n;
					chunked_n    = lch_n;
					chunk_left_n = lcl_n;
					done         = l_done;
					if (l_err) err = ERR_STATUS;
					if (is_end && phase == PH_HEADERS) body_cnt_n = '0;
				end
				PH_CONTENT: begin
					bv = 1'b1;
					if (body_cnt != LEN_MAX) body_cnt_n = body_cnt + 1'b1;
					if (len_known && body_cnt_n >= decl_len) begin
						phase_n = PH_DONE;
						done    = 1'b1;
					end
				end
				PH_DATA: begin
					bv = 1'b1;
					if (body_cnt != LEN_MAX) body_cnt_n = body_cnt + 1'b1;
					cl_dec = (chunk_left != '0) ? chunk_left - 1'b1 : chunk_left;
					chunk_left_n = cl_dec;
					if (cl_dec == '0) begin
						phase_n    = PH_TRAILER;
						trl_step_n = 1'b0;
					end
				end
				default: begin
					if (!trl_step && c == 8'h0D) trl_step_n = 1'b1;
					else if (trl_step && c == 8'h0A) begin
						trl_step_n = 1'b0;
						phase_n    = PH_SIZE;
						line_pos_n = '0;
						prev_cr_n  = 1'b0;
						hm_flags_n = '0;
						value_acc_n = '0;
					end else begin
						phase_n = PH_ERROR;
						err     = ERR_TRAILER;
					end
				end
			endcase
		end
		result.body_valid    = bv;
		result.body_byte     = bv ? c : 8'd0;
		result.resp_status   = (phase_n == PH_STATUS) ? 10'd0 : status_acc_n;
		result.response_done = done;
		result.error_kind    = err;
	end

endmodule

// File: rtl/http_response_deframer.sv
// HTTP/1.1 response deframer. One transaction on in_ch is one received byte or an
// end-of-stream event; each gives exactly one result transaction on out_ch carrying
// the body byte (chunk framing removed), the accepted status code, a done pulse and
// an error code. The whole parse step is a single combinational pass from the state
// registers into the output register, so the block takes a byte every cycle while
// out_ch is ready, and keeps taking one while a result waits as long as the output
// register frees in the same cycle. After done or an error the block ignores input
// until reset.
module http_response_deframer
	import hrd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	hrd_stream_if.sink   in_ch,
	hrd_stream_if.source out_ch
);

	phase_t     phase_q, phase_n;
	logic [7:0] line_pos_q, line_pos_n;
	logic       prev_cr_q, prev_cr_n;
	logic [9:0] status_acc_q, status_acc_n;
	logic [3:0] sl_flags_q, sl_flags_n;
	logic [3:0] hm_flags_q, hm_flags_n;
	len_t       value_acc_q, value_acc_n;
	logic       len_known_q, len_known_n;
	len_t       decl_len_q, decl_len_n;
	logic       chunked_q, chunked_n;
	len_t       body_cnt_q, body_cnt_n;
	len_t       chunk_left_q, chunk_left_n;
	logic       trl_step_q, trl_step_n;
	out_item_t  res;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       take;

	assign in_ch.ready    = !out_valid_q || out_ch.ready;
	assign take           = in_ch.valid && in_ch.ready;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	hrd_core u_core (
		.phase(phase_q), .line_pos(line_pos_q), .prev_cr(prev_cr_q),
		.status_acc(status_acc_q), .sl_flags(sl_flags_q), .hm_flags(hm_flags_q),
		.value_acc(value_acc_q), .len_known(len_known_q), .decl_len(decl_len_q),
		.chunked(chunked_q), .body_cnt(body_cnt_q), .chunk_left(chunk_left_q),
		.trl_step(trl_step_q), .item(in_ch.payload),
		.phase_n(phase_n), .line_pos_n(line_pos_n), .prev_cr_n(prev_cr_n),
		.status_acc_n(status_acc_n), .sl_flags_n(sl_flags_n), .hm_flags_n(hm_flags_n),
		.value_acc_n(value_acc_n), .len_known_n(len_known_n), .decl_len_n(decl_len_n),
		.chunked_n(chunked_n), .body_cnt_n(body_cnt_n), .chunk_left_n(chunk_left_n),
		.trl_step_n(trl_step_n), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STATUS;
			line_pos_q   <= '0;
			prev_cr_q    <= 1'b0;
			status_acc_q <= '0;
			sl_flags_q   <= '0;
			hm_flags_q   <= '0;
			value_acc_q  <= '0;
			len_known_q  <= 1'b0;
			decl_len_q   <= '0;
			chunked_q    <= 1'b0;
			body_cnt_q   <= '0;
			chunk_left_q <= '0;
			trl_step_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				phase_q      <= phase_n;
				line_pos_q   <= line_pos_n;
				prev_cr_q    <= prev_cr_n;
				status_acc_q <= status_acc_n;
				sl_flags_q   <= sl_flags_n;
				hm_flags_q   <= hm_flags_n;
				value_acc_q  <= value_acc_n;
				len_known_q  <= len_known_n;
				decl_len_q   <= decl_len_n;
				chunked_q    <= chunked_n;
				body_cnt_q   <= body_cnt_n;
				chunk_left_q <= chunk_left_n;
				trl_step_q   <= trl_step_n;
				out_valid_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.response_done && out_q.error_kind != ERR_NONE))
		else $error("done and error in one result");
	a_terminal_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE || phase_q == PH_ERROR) |=>
		(phase_q == PH_DONE || phase_q == PH_ERROR))
		else $error("left terminal phase");
	a_body_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.body_valid |-> (phase_q == PH_CONTENT || phase_q == PH_DATA))
		else $error("body byte outside body phase");

endmodule

// File: bench/http_response_deframer_tb.sv
`timescale 1ns / 1ps

module http_response_deframer_tb
	import hrd_pkg::*;
();

	localparam logic [63:0] LMAX = 64'(LEN_MAX);

	typedef struct {
		logic      has;
		out_item_t v;
	} pinned_t;

	typedef struct {
		in_item_t  it;
		logic      has;
		out_item_t v;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hrd_stream_if #(.payload_t(in_item_t))  in_ch();
	hrd_stream_if #(.payload_t(out_item_t)) out_ch();

	http_response_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	out_item_t expected_results[$];
	pinned_t   pinned[$];
	int        mismatches = 0;
	int        sent = 0;
	bit        src_idle = 1'b1;
	bit        snk_idle = 1'b1;
	bit        long_hold_req = 1'b0;

	// parser mirror
	phase_t      ph;
	int unsigned lpos;
	bit          pcr;
	int unsigned stat;
	bit [3:0]    sflags, hflags;
	logic [63:0] vacc, dlen, bcnt, cleft;
	bit          lknown, chunked;
	bit [1:0]    tstep;
	bit          pdone;
	bit [1:0]    perr;

	function automatic bit ws(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] lc(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int hexv(logic [7:0] c);
		logic [7:0] l;
		l = lc(c);
		if (c >= "0" && c <= "9") return c - "0";
		if (l >= "a" && l <= "f") return l - "a" + 10;
		return -1;
	endfunction

	function automatic logic [63:0] sat(logic [63:0] acc, logic [63:0] d, logic [63:0] base,
			logic [63:0] mx);
		if (acc > (mx - d) / base) return mx;
		return acc * base + d;
	endfunction

	function automatic int unsigned bump(int unsigned p);
		return p < 255 ? p + 1 : 255;
	endfunction

	function automatic int unsigned dec_digit(int unsigned st, logic [7:0] c,
			inout logic [63:0] acc, inout bit neg, input logic [63:0] mx);
		if (st == 0) begin
			if (ws(c)) return 0;
			if (c == "+") return 1;
			if (c == "-") begin
				neg = 1'b1;
				return 1;
			end
		end
		if (st <= 2 && c >= "0" && c <= "9") begin
			acc = sat(acc, c - "0", 10, mx);
			return 2;
		end
		return 3;
	endfunction

	function automatic void clear_line();
		lpos = 0;
		pcr = 1'b0;
		hflags = '0;
		vacc = '0;
	endfunction

	function automatic void status_ch(logic [7:0] c);
		string       proto = "HTTP/1.";
		logic [63:0] acc;
		bit          neg;
		int unsigned st;
		if (lpos < 7 && c != proto[lpos]) sflags[0] = 1'b1;
		if (!sflags[1]) begin
			if (c == " ") sflags[1] = 1'b1;
		end else begin
			acc = stat;
			neg = 1'b0;
			st = dec_digit(sflags[3:2], c, acc, neg, 1000);
			if (neg) begin
				st = 3;
				acc = 0;
			end
			stat = acc;
			sflags[3:2] = st[1:0];
		end
		lpos = bump(lpos);
	endfunction

	function automatic void header_ch(logic [7:0] c);
		string    cl = "content-length";
		string    te = "transfer-encoding";
		string    ck = "chunked";
		bit [3:0] f;
		bit       neg;
		f = hflags;
		if (!f[2]) begin
			if (c == ":") begin
				hflags = 4'b0100;
				if (!f[0] && lpos == 14) hflags[0] = 1'b1;
				if (!f[1] && lpos == 17) hflags[1] = 1'b1;
				lpos = 0;
				vacc = '0;
				return;
			end
			if (lpos >= 14 || lc(c) != cl[lpos]) f[0] = 1'b1;
			if (lpos >= 17 || lc(c) != te[lpos]) f[1] = 1'b1;
			hflags = f;
			lpos = bump(lpos);
			return;
		end
		if (f[0]) begin
			neg = f[3];
			lpos = dec_digit(lpos & 3, c, vacc, neg, LMAX);
			if (neg) hflags[3] = 1'b1;
		end else if (f[1]) begin
			if (!f[3]) begin
				if (c == " ") return;
				hflags[3] = 1'b1;
			end
			if (lpos < 7) lpos = (lc(c) == ck[lpos]) ? lpos + 1 : 8;
		end
	endfunction

	function automatic void size_ch(logic [7:0] c);
		int          h;
		int unsigned p;
		p = lpos;
		lpos = bump(p);
		if (p >= SIZE_LINE_LIMIT) return;
		if (hflags == 0 && ws(c)) return;
		if (hflags <= 1) begin
			h = hexv(c);
			if (h >= 0) begin
				vacc = sat(vacc, h, 16, LMAX);
				hflags = 1;
				return;
			end
		end
		hflags = 2;
	endfunction

	function automatic void line_ch(logic [7:0] c);
		if (ph == PH_STATUS) status_ch(c);
		else if (ph == PH_HEADERS) header_ch(c);
		else size_ch(c);
	endfunction

	function automatic void headers_over();
		if (chunked) ph = PH_SIZE;
		else if (lknown && dlen > 0) ph = PH_CONTENT;
		else if (lknown || stat == 204 || stat == 304) begin
			ph = PH_DONE;
			pdone = 1'b1;
		end else ph = PH_CONTENT;
		bcnt = '0;
	endfunction

	function automatic void line_done();
		if (ph == PH_STATUS) begin
			if (lpos >= MIN_STATUS_LINE && !sflags[0] && sflags[1] && stat >= 100
					&& stat <= 599) begin
				ph = PH_HEADERS;
				lknown = 1'b0;
				chunked = 1'b0;
			end else begin
				ph = PH_ERROR;
				stat = 0;
				perr = ERR_STATUS;
			end
		end else if (ph == PH_HEADERS) begin
			if (!hflags[2]) begin
				if (lpos == 0) headers_over();
			end else if (hflags[0]) begin
				if (hflags[3] && vacc != 0) lknown = 1'b0;
				else begin
					lknown = 1'b1;
					dlen = vacc;
				end
			end else if (hflags[1]) begin
				if (lpos == 7) chunked = 1'b1;
			end
		end else begin
			if (vacc == 0) begin
				ph = PH_DONE;
				pdone = 1'b1;
			end else begin
				cleft = vacc;
				ph = PH_DATA;
			end
		end
		clear_line();
	endfunction

	function automatic void line_in(logic [7:0] c);
		if (pcr) begin
			pcr = 1'b0;
			if (c == 8'h0A) begin
				line_done();
				return;
			end
			line_ch(8'h0D);
		end
		if (c == 8'h0D) pcr = 1'b1;
		else line_ch(c);
	endfunction

	function automatic void parser_reset();
		ph = PH_STATUS;
		clear_line();
		stat = 0;
		sflags = '0;
		lknown = 1'b0;
		dlen = '0;
		chunked = 1'b0;
		bcnt = '0;
		cleft = '0;
		tstep = '0;
	endfunction

	function automatic out_item_t deframe(in_item_t it);
		out_item_t r;
		logic [7:0] c;
		r = '0;
		c = it.data_byte;
		pdone = 1'b0;
		perr = ERR_NONE;
		if (ph == PH_DONE || ph == PH_ERROR) begin
		end else if (it.req_type == REQ_EOS) begin
			if (ph == PH_CONTENT && !lknown) begin
				ph = PH_DONE;
				pdone = 1'b1;
			end else begin
				ph = PH_ERROR;
				perr = ERR_EOS;
			end
		end else if (ph == PH_STATUS || ph == PH_HEADERS || ph == PH_SIZE) begin
			line_in(c);
		end else if (ph == PH_CONTENT || ph == PH_DATA) begin
			r.body_valid = 1'b1;
			r.body_byte = c;
			if (bcnt < LMAX) bcnt++;
			if (ph == PH_CONTENT) begin
				if (lknown && bcnt >= dlen) begin
					ph = PH_DONE;
					pdone = 1'b1;
				end
			end else begin
				if (cleft > 0) cleft--;
				if (cleft == 0) begin
					ph = PH_TRAILER;
					tstep = 0;
				end
			end
		end else begin
			if (tstep == 0 && c == 8'h0D) tstep = 1;
			else if (tstep == 1 && c == 8'h0A) begin
				tstep = 0;
				ph = PH_SIZE;
				clear_line();
			end else begin
				ph = PH_ERROR;
				perr = ERR_TRAILER;
			end
		end
		r.resp_status = (ph == PH_STATUS) ? 10'd0 : stat[9:0];
		r.response_done = pdone;
		r.error_kind = perr;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		out_item_t p, o;
		pinned_t   pe;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				p = deframe(in_ch.payload);
				if (pinned.size() > 0) begin
					pe = pinned.pop_front();
					if (pe.has) p = pe.v;
				end
				expected_results.push_back(p);
			end
			if (out_ch.valid && out_ch.ready) begin
				o = out_ch.payload;
				if (expected_results.size() == 0) begin
					report("unexpected transaction", 1, 0);
				end else begin
					p = expected_results.pop_front();
					if (o.body_valid !== p.body_valid)
						report("body_valid", o.body_valid, p.body_valid);
					if (o.body_byte !== p.body_byte)
						report("body_byte", o.body_byte, p.body_byte);
					if (o.resp_status !== p.resp_status)
						report("resp_status", o.resp_status, p.resp_status);
					if (o.response_done !== p.response_done)
						report("response_done", o.response_done, p.response_done);
					if (o.error_kind !== p.error_kind)
						report("error_kind", o.error_kind, p.error_kind);
				end
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	initial begin : receiver
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 300;
			end else if (hold == 0 && snk_idle && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 15);
			end
			if (hold > 0) hold--;
			out_ch.ready <= (hold == 0) && arst_n;
		end
	end

	task automatic send_txn(logic req, logic [7:0] b);
		int g;
		@(negedge clk);
		if (src_idle && $urandom_range(0, 9) == 0) begin
			g = $urandom_range(1, 15);
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{req_type: req, data_byte: b};
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic send_str(string s);
		foreach (s[i]) send_txn(REQ_BYTE, s[i]);
	endtask

	function automatic string mixcase(string s);
		foreach (s[i])
			if ($urandom_range(0, 1)) begin
				if (s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
				else if (s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 8'd32;
			end
		return s;
	endfunction

	initial begin : stimulus
		string     status_line;
		row_t      rows[$];
		row_t      r;
		pinned_t   pe;
		string     s;
		int        n, k;
		out_item_t z;

		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		parser_reset();

		// status line with a plus sign and the top code; result is zero until the LF
		status_line = "HTTP/1.1 +599\r\n";
		z = '0;
		foreach (status_line[i]) begin
			r.it = '{req_type: REQ_BYTE, data_byte: status_line[i]};
			r.has = 1'b1;
			r.v = z;
			if (i == status_line.len() - 1) r.v.resp_status = 10'd599;
			rows.push_back(r);
		end
		// header bytes with a lone LF and a CR inside a value: predictor checks these
		s = "X-a: b\nc\rd\r\n";
		foreach (s[i]) begin
			r.it = '{req_type: REQ_BYTE, data_byte: s[i]};
			r.has = 1'b0;
			rows.push_back(r);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			pe.has = rows[i].has;
			pe.v = rows[i].v;
			pinned.push_back(pe);
			send_txn(rows[i].it.req_type, rows[i].it.data_byte);
		end

		// remaining headers: noise, length fields that chunked framing overrides
		n = $urandom_range(1, 4);
		for (int h = 0; h < n; h++) begin
			case ($urandom_range(0, 3))
				0: s = $sformatf("%s: %0d\r\n", mixcase("content-length"),
						$urandom_range(0, 99999));
				1: s = $sformatf("%s:-%0d\r\n", mixcase("content-length"),
						$urandom_range(1, 50));
				2: s = $sformatf("%s: gzip\r\n", mixcase("transfer-encoding"));
				default: s = $sformatf("X-%0d: v%0h\r\n", h, $urandom);
			endcase
			send_str(s);
		end
		send_str({mixcase("Transfer-Encoding"), ":  ", mixcase("chunked"), "\r\n\r\n"});

		// chunked body until the item budget is spent
		k = 0;
		while (sent < 1060) begin
			if (sent > 900) begin
				src_idle = 1'b0;
				snk_idle = 1'b0;
			end
			if (k == 4) long_hold_req = 1'b1;
			if (k == 12) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				wait (expected_results.size() == 0);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 24);
			s = mixcase($sformatf("%h", n[7:0]));
			if ($urandom_range(0, 3) == 0) s = {" ", s};
			if ($urandom_range(0, 3) == 0) s = {s, ";ext=", mixcase("ab")};
			send_str({s, "\r\n"});
			repeat (n) send_txn(REQ_BYTE, 8'($urandom_range(0, 255)));
			send_str("\r\n");
			k++;
		end
		send_str("0\r\n");
		// after completion input is ignored
		send_str("\r\n");
		send_txn(REQ_EOS, 8'($urandom_range(0, 255)));
		@(negedge clk);
		in_ch.valid <= 1'b0;

		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/hrd_pkg.sv
rtl/hrd_stream_if.sv
rtl/hrd_core.sv
rtl/http_response_deframer.sv
bench/http_response_deframer_tb.sv
